FILE: src/cartesian_polar_converter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coordinate converter
// Clocked, reset-qualified property forms used by the converter top level.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_POLAR_CONVERTER_TOP_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate converter package
// Widths, CORDIC constants, arctangent table and the stage data type.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int GUARD       = 16;
    localparam int ANGLE_W     = 16;
    localparam int TURN_W      = 32;
    localparam int RES_W       = COORD_WIDTH + 1;
    localparam int X_W         = COORD_WIDTH + GUARD + 4;
    localparam int Z_W         = TURN_W + 2;
    localparam int IDX_W       = $clog2(ITERATIONS);
    localparam int ATAN_DEPTH  = 32;
    localparam int ATAN_IDX_W  = 5;
    localparam int IK_W        = 32;
    localparam int IK_FRAC     = 30;
    localparam int PI2_W       = 32;
    localparam int PI2_FRAC    = 28;
    localparam int ANG_SHIFT   = TURN_W - ANGLE_W;

    // Mode codes
    localparam logic FUNC_TO_POLAR = 1'b0;
    localparam logic FUNC_TO_CART  = 1'b1;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [TURN_W-1:0] ATAN_TURN32 [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335088,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // Residual angle after the last stage stays within the last table entry
    localparam int ZRES_W = $clog2(ATAN_TURN32[ITERATIONS-1] + 1) + 4;
    localparam int ZR_W   = ZRES_W + 4;

    // 2*pi in Q28
    localparam logic signed [PI2_W-1:0] TWO_PI_Q28 = 32'sd1686629713;

    // 1/K in Q30 for ITERATIONS stages, worked out at elaboration
    function automatic logic [63:0] calc_inv_gain_q30();
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] bsel;
        logic [63:0] rem;
        logic [63:0] quo;
        p = 64'd1 << 60;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            p = p + (p >> (2 * i));
        end
        v    = p;
        root = '0;
        bsel = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bsel > v)
            begin
                bsel = bsel >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bsel != '0)
            begin
                if (v >= root + bsel)
                begin
                    v    = v - (root + bsel);
                    root = (root >> 1) + bsel;
                end
                else
                begin
                    root = root >> 1;
                end
                bsel = bsel >> 2;
            end
        end
        if (root == '0)
        begin
            root = 64'd1;
        end
        rem = '0;
        quo = '0;
        for (int i = 60; i >= 0; i--)
        begin
            rem = {rem[62:0], (i == 60)};
            quo = {quo[62:0], 1'b0};
            if (rem >= root)
            begin
                rem    = rem - root;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    localparam logic signed [IK_W-1:0] INV_GAIN_Q30 = IK_W'(calc_inv_gain_q30());

    // Half a turn in the angle accumulator
    localparam logic signed [Z_W-1:0] Z_HALF_TURN =
        {{(Z_W-TURN_W){1'b0}}, 1'b1, {(TURN_W-1){1'b0}}};

    // Vector handed from cell to cell
    typedef struct packed {
        logic                  func;
        logic                  zero;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cpc_vec_t;

endpackage

FILE: src/cpc_front.sv
// ----------------------------------------------------------------------------
// Coordinate converter front end
// Gain pre-scale multiply, then quadrant folding and angle setup.
// ----------------------------------------------------------------------------
module cpc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] coord_a,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] coord_b,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output cpc_pkg::cpc_vec_t                      out_data
);

    localparam int PROD_W = cpc_pkg::COORD_WIDTH + cpc_pkg::IK_W;
    localparam int MSB    = cpc_pkg::ANGLE_W - 1;

    // Scale stage
    logic                               s1_valid_reg, s1_valid_next;
    logic                               s1_take;
    logic                               s1_func_reg;
    logic                               s1_zero_reg, s1_zero_next;
    logic signed [cpc_pkg::X_W-1:0]     s1_x_reg, s1_x_next;
    logic signed [cpc_pkg::X_W-1:0]     s1_y_reg, s1_y_next;
    logic [cpc_pkg::ANGLE_W-1:0]        s1_angle_reg, s1_angle_next;
    logic signed [PROD_W-1:0]           prod_a, prod_b;

    // Fold stage
    logic                               s2_valid_reg, s2_valid_next;
    logic                               s2_take;
    cpc_pkg::cpc_vec_t                  s2_data_reg, s2_data_next;
    logic                               flip;
    logic [cpc_pkg::TURN_W-1:0]         theta;

    assign s2_take  = !s2_valid_reg || out_ready;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign in_ready = s1_take;

    assign prod_a        = coord_a * cpc_pkg::INV_GAIN_Q30;
    assign prod_b        = coord_b * cpc_pkg::INV_GAIN_Q30;
    assign s1_x_next     = cpc_pkg::X_W'(prod_a >>> (cpc_pkg::IK_FRAC - cpc_pkg::GUARD));
    assign s1_y_next     = cpc_pkg::X_W'(prod_b >>> (cpc_pkg::IK_FRAC - cpc_pkg::GUARD));
    assign s1_zero_next  = (coord_a == '0) && (coord_b == '0);
    assign s1_angle_next = cpc_pkg::ANGLE_W'(coord_b);
    assign s1_valid_next = s1_take ? in_valid : s1_valid_reg;

    // Second and third quadrant: turn by pi and negate r
    assign flip  = s1_angle_reg[MSB] ^ s1_angle_reg[MSB-1];
    assign theta = {s1_angle_reg[MSB] ^ flip, s1_angle_reg[MSB-1:0],
                    {cpc_pkg::ANG_SHIFT{1'b0}}};

    always_comb
    begin
        s2_data_next.func = s1_func_reg;
        s2_data_next.zero = s1_zero_reg;
        unique case (s1_func_reg)
            cpc_pkg::FUNC_TO_POLAR:
            begin
                // Left half plane: turn by pi first
                s2_data_next.x = s1_x_reg[cpc_pkg::X_W-1] ? -s1_x_reg : s1_x_reg;
                s2_data_next.y = s1_x_reg[cpc_pkg::X_W-1] ? -s1_y_reg : s1_y_reg;
                s2_data_next.z = s1_x_reg[cpc_pkg::X_W-1] ? cpc_pkg::Z_HALF_TURN : '0;
            end
            cpc_pkg::FUNC_TO_CART:
            begin
                s2_data_next.x = flip ? -s1_x_reg : s1_x_reg;
                s2_data_next.y = '0;
                s2_data_next.z = cpc_pkg::Z_W'(signed'(theta));
            end
            default:
            begin
                s2_data_next.x = s1_x_reg;
                s2_data_next.y = s1_y_reg;
                s2_data_next.z = '0;
            end
        endcase
    end

    assign s2_valid_next = s2_take ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && in_valid)
        begin
            s1_func_reg  <= func;
            s1_zero_reg  <= s1_zero_next;
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_angle_reg <= s1_angle_next;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

FILE: src/cpc_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation by atan(2^-i), registered, with its own handshake.
// ----------------------------------------------------------------------------
module cpc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [cpc_pkg::IDX_W-1:0]  stage_idx,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cpc_pkg::cpc_vec_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cpc_pkg::cpc_vec_t          out_data
);

    logic                           valid_reg, valid_next;
    logic                           take;
    logic                           ccw;
    cpc_pkg::cpc_vec_t              data_reg, data_next;
    logic signed [cpc_pkg::X_W-1:0] x_sh, y_sh;
    logic signed [cpc_pkg::Z_W-1:0] atan_val;

    assign take     = !valid_reg || out_ready;
    assign in_ready = take;

    assign x_sh     = in_data.x >>> stage_idx;
    assign y_sh     = in_data.y >>> stage_idx;
    assign atan_val = cpc_pkg::Z_W'(cpc_pkg::ATAN_TURN32[cpc_pkg::ATAN_IDX_W'(stage_idx)]);

    // Vectoring drives y to zero, rotation drives z to zero
    always_comb
    begin
        unique case (in_data.func)
            cpc_pkg::FUNC_TO_POLAR: ccw = in_data.y[cpc_pkg::X_W-1] || (in_data.y == '0);
            cpc_pkg::FUNC_TO_CART:  ccw = !in_data.z[cpc_pkg::Z_W-1];
            default:                ccw = 1'b0;
        endcase
    end

    always_comb
    begin
        data_next = in_data;
        if (ccw)
        begin
            data_next.x = in_data.x - y_sh;
            data_next.y = in_data.y + x_sh;
            data_next.z = in_data.z - atan_val;
        end
        else
        begin
            data_next.x = in_data.x + y_sh;
            data_next.y = in_data.y - x_sh;
            data_next.z = in_data.z + atan_val;
        end
    end

    assign valid_next = take ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/cpc_back.sv
// ----------------------------------------------------------------------------
// Coordinate converter back end
// Residual-angle correction, rounding and the output register.
// ----------------------------------------------------------------------------
module cpc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cpc_pkg::cpc_vec_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [cpc_pkg::RES_W-1:0] result_a,
    output logic signed [cpc_pkg::RES_W-1:0] result_b
);

    localparam int XH_W   = cpc_pkg::X_W - cpc_pkg::GUARD;
    localparam int ZP_W   = cpc_pkg::ZRES_W + cpc_pkg::PI2_W;
    localparam int CP_W   = XH_W + cpc_pkg::ZR_W;
    localparam int CP_SH  = cpc_pkg::TURN_W - cpc_pkg::GUARD;
    localparam logic signed [cpc_pkg::X_W:0] ROUND_HALF =
        {{(cpc_pkg::X_W-cpc_pkg::GUARD+1){1'b0}}, 1'b1, {(cpc_pkg::GUARD-1){1'b0}}};
    localparam logic signed [cpc_pkg::Z_W-1:0] ANG_HALF =
        {{(cpc_pkg::Z_W-cpc_pkg::ANG_SHIFT){1'b0}}, 1'b1, {(cpc_pkg::ANG_SHIFT-1){1'b0}}};
    localparam logic [cpc_pkg::ANGLE_W-1:0] ANGLE_PI =
        {1'b1, {(cpc_pkg::ANGLE_W-1){1'b0}}};

    // Residual angle in radians
    logic                              zs_valid_reg, zs_valid_next;
    logic                              zs_take;
    cpc_pkg::cpc_vec_t                 zs_data_reg;
    logic signed [cpc_pkg::ZR_W-1:0]   zs_zr_reg, zs_zr_next;
    logic signed [cpc_pkg::ZRES_W-1:0] zres;
    logic signed [ZP_W-1:0]            prod_zr;

    // Correction terms
    logic                              cr_valid_reg, cr_valid_next;
    logic                              cr_take;
    cpc_pkg::cpc_vec_t                 cr_data_reg;
    logic signed [cpc_pkg::X_W-1:0]    cr_dx_reg, cr_dx_next;
    logic signed [cpc_pkg::X_W-1:0]    cr_dy_reg, cr_dy_next;
    logic signed [XH_W-1:0]            xh, yh;
    logic signed [CP_W-1:0]            prod_dx, prod_dy;

    // Output register
    logic                              o_valid_reg, o_valid_next;
    logic                              o_take;
    logic signed [cpc_pkg::RES_W-1:0]  result_a_reg, result_a_next;
    logic signed [cpc_pkg::RES_W-1:0]  result_b_reg, result_b_next;
    logic signed [cpc_pkg::X_W:0]      sum_a, sum_b;
    logic signed [cpc_pkg::Z_W-1:0]    zsum;
    logic [cpc_pkg::ANGLE_W-1:0]       ang;
    logic signed [cpc_pkg::RES_W-1:0]  ang_res;

    assign o_take   = !o_valid_reg || out_ready;
    assign cr_take  = !cr_valid_reg || o_take;
    assign zs_take  = !zs_valid_reg || cr_take;
    assign in_ready = zs_take;

    assign zres       = in_data.z[cpc_pkg::ZRES_W-1:0];
    assign prod_zr    = zres * cpc_pkg::TWO_PI_Q28;
    assign zs_zr_next = cpc_pkg::ZR_W'(prod_zr >>> cpc_pkg::PI2_FRAC);

    assign xh      = XH_W'(zs_data_reg.x >>> cpc_pkg::GUARD);
    assign yh      = XH_W'(zs_data_reg.y >>> cpc_pkg::GUARD);
    assign prod_dx = yh * zs_zr_reg;
    assign prod_dy = xh * zs_zr_reg;
    assign cr_dx_next = (zs_data_reg.func == cpc_pkg::FUNC_TO_CART)
                      ? cpc_pkg::X_W'(prod_dx >>> CP_SH) : '0;
    assign cr_dy_next = (zs_data_reg.func == cpc_pkg::FUNC_TO_CART)
                      ? cpc_pkg::X_W'(prod_dy >>> CP_SH) : '0;

    assign sum_a = (cpc_pkg::X_W+1)'(cr_data_reg.x) - (cpc_pkg::X_W+1)'(cr_dx_reg) + ROUND_HALF;
    assign sum_b = (cpc_pkg::X_W+1)'(cr_data_reg.y) + (cpc_pkg::X_W+1)'(cr_dy_reg) + ROUND_HALF;
    assign zsum  = cr_data_reg.z + ANG_HALF;
    assign ang   = zsum[cpc_pkg::TURN_W-1:cpc_pkg::ANG_SHIFT];

    // Minus pi is reported as plus pi
    assign ang_res = (ang == ANGLE_PI) ? cpc_pkg::RES_W'(signed'({1'b0, ang}))
                                       : cpc_pkg::RES_W'(signed'(ang));

    always_comb
    begin
        unique case (cr_data_reg.func)
            cpc_pkg::FUNC_TO_POLAR:
            begin
                if (cr_data_reg.zero)
                begin
                    result_a_next = '0;
                    result_b_next = '0;
                end
                else
                begin
                    result_a_next = cpc_pkg::RES_W'(sum_a >>> cpc_pkg::GUARD);
                    result_b_next = ang_res;
                end
            end
            cpc_pkg::FUNC_TO_CART:
            begin
                result_a_next = cpc_pkg::RES_W'(sum_a >>> cpc_pkg::GUARD);
                result_b_next = cpc_pkg::RES_W'(sum_b >>> cpc_pkg::GUARD);
            end
            default:
            begin
                result_a_next = '0;
                result_b_next = '0;
            end
        endcase
    end

    assign zs_valid_next = zs_take ? in_valid : zs_valid_reg;
    assign cr_valid_next = cr_take ? zs_valid_reg : cr_valid_reg;
    assign o_valid_next  = o_take ? cr_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zs_valid_reg <= 1'b0;
            cr_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            zs_valid_reg <= zs_valid_next;
            cr_valid_reg <= cr_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (zs_take && in_valid)
        begin
            zs_data_reg <= in_data;
            zs_zr_reg   <= zs_zr_next;
        end
        if (cr_take && zs_valid_reg)
        begin
            cr_data_reg <= zs_data_reg;
            cr_dx_reg   <= cr_dx_next;
            cr_dy_reg   <= cr_dy_next;
        end
        if (o_take && cr_valid_reg)
        begin
            result_a_reg <= result_a_next;
            result_b_reg <= result_b_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign result_a  = result_a_reg;
    assign result_b  = result_b_reg;

endmodule

FILE: src/cartesian_polar_converter_top.sv
// ----------------------------------------------------------------------------
// Cartesian / polar coordinate converter
// Pipelined CORDIC converter between (x, y) and (magnitude, angle).
// ----------------------------------------------------------------------------
// Each transaction carries a mode bit and two signed 16-bit coordinates. With
// func = 0, (coord_a, coord_b) is (x, y) and the block returns the magnitude
// on result_a and atan2(y, x) on result_b in units of pi/32768 (-32767 to
// +32768, the zero vector gives 0, 0). With func = 1, coord_a is a signed
// radius r and coord_b an angle in pi/32768 units wrapping over one turn; the
// block returns r*cos on result_a and r*sin on result_b. All results are
// rounded to the nearest unit. The datapath is a row of ITERATIONS CORDIC
// cells, one micro-rotation each, between a two-stage front end (gain
// pre-scale multiply, quadrant folding) and a three-stage back end (residual
// angle multiply, correction multiplies, rounding into the output register).
// A new transaction is accepted every clock cycle while the output is not
// stalled. Every stage has its own valid bit and moves forward whenever the
// stage after it is empty or emptying, so bubbles close up and the input
// keeps flowing while a result waits in the output register. There is no
// configuration and no state between transactions.
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_top_assert.svh"

module cartesian_polar_converter_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] coord_a,
    input  logic signed [cpc_pkg::COORD_WIDTH-1:0] coord_b,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cpc_pkg::RES_W-1:0]       result_a,
    output logic signed [cpc_pkg::RES_W-1:0]       result_b
);

    // Handshake and data between neighboring stages of the cell row:
    // index 0 is the front end output, index ITERATIONS feeds the back end.
    logic              front_ready;
    logic              chain_valid [cpc_pkg::ITERATIONS+1];
    logic              chain_ready [cpc_pkg::ITERATIONS+1];
    cpc_pkg::cpc_vec_t chain_data  [cpc_pkg::ITERATIONS+1];

    // Hold the input whenever the front end cannot take a transaction
    assign in_stall = !front_ready;

    // Pre-scale by 1/K and fold the input into the right half plane
    cpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .func      (func),
        .coord_a   (coord_a),
        .coord_b   (coord_b),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Row of micro-rotation cells; cell g shifts by g and uses atan(2^-g)
    for (genvar g = 0; g < cpc_pkg::ITERATIONS; g++)
    begin : g_cell
        cpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (cpc_pkg::IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // Correct the residual angle, round, and hold the result for the sink
    cpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[cpc_pkg::ITERATIONS]),
        .in_ready  (chain_ready[cpc_pkg::ITERATIONS]),
        .in_data   (chain_data[cpc_pkg::ITERATIONS]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .result_a  (result_a),
        .result_b  (result_b)
    );

    // The input stalls only when the front end holds a transaction it cannot pass on
    `CPC_ASSERT_NOW(a_stall_needs_full_front, in_stall, chain_valid[0], "input stalled with empty front end")

    // The back end refuses a transaction only when its output register is occupied
    `CPC_ASSERT_NOW(a_back_full_has_output, !chain_ready[cpc_pkg::ITERATIONS], out_valid, "back end blocked with no result pending")

    // A transaction taken by the first cell shows up there on the next cycle
    `CPC_ASSERT_NEXT(a_first_cell_loads, chain_valid[0] && chain_ready[0], chain_valid[1], "first cell dropped a transaction")

endmodule
